>>> sv/fqp_pkg.sv
// shared constants and types for the fastq record parser
`timescale 1ns / 1ps

package fqp_pkg;

    localparam int MAX_NAME_DEF = 256;
    localparam int LEN_BITS_DEF = 20;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_code;

    localparam t_byte CH_AT   = 8'h40;
    localparam t_byte CH_PLUS = 8'h2B;
    localparam t_byte CH_CR   = 8'h0D;
    localparam t_byte CH_LF   = 8'h0A;
    localparam t_byte CH_SP   = 8'h20;
    localparam t_byte CH_TAB  = 8'h09;

    localparam t_code CLS_NAME    = 3'd0;
    localparam t_code CLS_COMMENT = 3'd1;
    localparam t_code CLS_BASE    = 3'd2;
    localparam t_code CLS_QUAL    = 3'd3;
    localparam t_code CLS_SEP     = 3'd4;

    localparam t_code ERR_OK        = 3'd0;
    localparam t_code ERR_NO_AT     = 3'd1;
    localparam t_code ERR_NO_SEQ    = 3'd2;
    localparam t_code ERR_NAME      = 3'd3;
    localparam t_code ERR_LENGTH    = 3'd4;
    localparam t_code ERR_TRUNCATED = 3'd5;

endpackage

>>> sv/fqp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fastq_record_parser_core.sv
// fastq record parser top level: byte classifier with name store in ram
// output: each accepted word's result is registered in the output register
// throughput: one word per cycle unless stalled; the name ram read address is
//   prefetched from n_cmp_idx so each compare byte has its stored name byte ready
// reset: synchronous active low, returns the parser to expect-header, clears the
//   counters and empties the output register; the name ram is not cleared
`timescale 1ns / 1ps

module fastq_record_parser_core #(
    parameter int MAX_NAME = fqp_pkg::MAX_NAME_DEF,
    parameter int LEN_BITS = fqp_pkg::LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_input,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_byte_class,
    output logic [7:0]          o_byte_value,
    output logic                o_record_done,
    output logic                o_no_quality,
    output logic [LEN_BITS-1:0] o_read_length,
    output logic [2:0]          o_error_code,
    output logic [31:0]         o_line_number
);

    import fqp_pkg::*;

    localparam int AW = $clog2(MAX_NAME);
    localparam int NL = AW + 1;
    localparam logic [NL-1:0] NAME_MAX = NL'(MAX_NAME);

    localparam logic [3:0] PH_HEADER    = 4'd0;
    localparam logic [3:0] PH_NAME_WAIT = 4'd1;
    localparam logic [3:0] PH_NAME      = 4'd2;
    localparam logic [3:0] PH_COMMENT   = 4'd3;
    localparam logic [3:0] PH_SEQ       = 4'd4;
    localparam logic [3:0] PH_QNAME     = 4'd5;
    localparam logic [3:0] PH_QREST     = 4'd6;
    localparam logic [3:0] PH_QUAL      = 4'd7;
    localparam logic [3:0] PH_HALT      = 4'd8;

    logic [3:0]          r_phase, n_phase;
    logic [NL-1:0]       r_name_len, n_name_len;
    logic [NL-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_mismatch, n_mismatch;
    logic [LEN_BITS-1:0] r_base_cnt, n_base_cnt;
    logic [LEN_BITS-1:0] r_qual_cnt, n_qual_cnt;
    logic                r_line_start, n_line_start;
    logic [31:0]         r_line_cnt, n_line_cnt;

    logic                r_out_valid;
    t_code               r_class, n_class;
    t_byte               r_value, n_value;
    logic                r_done, n_done;
    logic                r_noq, n_noq;
    logic [LEN_BITS-1:0] r_len, n_len;
    t_code               r_err, n_err;
    logic [31:0]         r_line, n_line;

    logic        w_accept;
    logic        w_we;
    logic [AW-1:0] w_raddr;
    t_byte       w_rdata;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_raddr  = n_cmp_idx[AW-1:0];

    fqp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_name_len[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        t_byte b;
        logic  blank;
        logic  mm;
        b     = i_data_byte;
        blank = (b == CH_SP) || (b == CH_TAB);
        mm    = r_mismatch;

        n_phase      = r_phase;
        n_name_len   = r_name_len;
        n_cmp_idx    = r_cmp_idx;
        n_mismatch   = r_mismatch;
        n_base_cnt   = r_base_cnt;
        n_qual_cnt   = r_qual_cnt;
        n_line_start = r_line_start;
        n_line_cnt   = r_line_cnt;
        w_we         = 1'b0;

        n_class = CLS_SEP;
        n_value = b;
        n_done  = 1'b0;
        n_noq   = 1'b0;
        n_len   = '0;
        n_err   = ERR_OK;
        n_line  = r_line_cnt;

        if (w_accept && i_end_of_input) begin
            n_value = '0;
            unique case (r_phase)
                PH_NAME_WAIT, PH_NAME, PH_COMMENT, PH_QNAME, PH_QREST: begin
                    n_err = ERR_TRUNCATED;
                end
                PH_SEQ: begin
                    n_err = (r_base_cnt == '0) ? ERR_NO_SEQ : ERR_TRUNCATED;
                end
                PH_QUAL: begin
                    if (!r_line_start && r_qual_cnt == r_base_cnt) begin
                        n_done = 1'b1;
                        n_len  = r_base_cnt;
                    end else if (!r_line_start && r_qual_cnt > r_base_cnt) begin
                        n_err = ERR_LENGTH;
                    end else begin
                        n_err = ERR_TRUNCATED;
                    end
                end
                default: begin
                end
            endcase
            n_phase      = PH_HEADER;
            n_name_len   = '0;
            n_cmp_idx    = '0;
            n_mismatch   = 1'b0;
            n_base_cnt   = '0;
            n_qual_cnt   = '0;
            n_line_start = 1'b1;
            n_line_cnt   = '0;
        end else if (w_accept) begin
            n_line_cnt = r_line_cnt + ((b == CH_LF) ? 32'd1 : 32'd0);
            n_line     = n_line_cnt;
            if (b != CH_CR && r_phase != PH_HALT) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (b == CH_AT) begin
                            n_name_len   = '0;
                            n_cmp_idx    = '0;
                            n_mismatch   = 1'b0;
                            n_base_cnt   = '0;
                            n_qual_cnt   = '0;
                            n_line_start = 1'b1;
                            n_phase      = PH_NAME_WAIT;
                        end else if (b != CH_LF) begin
                            n_err   = ERR_NO_AT;
                            n_phase = PH_HALT;
                        end
                    end
                    PH_NAME_WAIT, PH_NAME: begin
                        if (b == CH_LF) begin
                            if (r_phase == PH_NAME) begin
                                n_phase      = PH_SEQ;
                                n_line_start = 1'b1;
                            end
                        end else if (blank) begin
                            n_phase = PH_COMMENT;
                        end else begin
                            n_class = CLS_NAME;
                            if (r_name_len < NAME_MAX) begin
                                w_we       = 1'b1;
                                n_name_len = r_name_len + 1'b1;
                            end
                            n_phase = PH_NAME;
                        end
                    end
                    PH_COMMENT: begin
                        if (b == CH_LF) begin
                            n_phase      = PH_SEQ;
                            n_line_start = 1'b1;
                        end else begin
                            n_class = CLS_COMMENT;
                        end
                    end
                    PH_SEQ: begin
                        if (b == CH_LF) begin
                            n_line_start = 1'b1;
                        end else if (r_line_start && r_base_cnt != '0 && b == CH_AT) begin
                            n_done       = 1'b1;
                            n_noq        = 1'b1;
                            n_len        = r_base_cnt;
                            n_name_len   = '0;
                            n_cmp_idx    = '0;
                            n_mismatch   = 1'b0;
                            n_base_cnt   = '0;
                            n_qual_cnt   = '0;
                            n_line_start = 1'b1;
                            n_phase      = PH_NAME_WAIT;
                        end else if (r_line_start && r_base_cnt != '0 && b == CH_PLUS) begin
                            n_cmp_idx  = '0;
                            n_mismatch = 1'b0;
                            n_phase    = PH_QNAME;
                        end else begin
                            n_class      = CLS_BASE;
                            n_base_cnt   = (&r_base_cnt) ? r_base_cnt
                                                         : r_base_cnt + 1'b1;
                            n_line_start = 1'b0;
                        end
                    end
                    PH_QNAME, PH_QREST: begin
                        if (b == CH_LF) begin
                            if (r_phase == PH_QNAME && r_cmp_idx != '0
                                && r_cmp_idx != r_name_len) begin
                                mm = 1'b1;
                            end
                            n_mismatch = mm;
                            if (mm) begin
                                n_err   = ERR_NAME;
                                n_phase = PH_HALT;
                            end else begin
                                n_phase      = PH_QUAL;
                                n_qual_cnt   = '0;
                                n_line_start = 1'b1;
                            end
                        end else if (r_phase == PH_QNAME) begin
                            if (blank) begin
                                if (r_cmp_idx != r_name_len) begin
                                    n_mismatch = 1'b1;
                                end
                                n_phase = PH_QREST;
                            end else if (r_cmp_idx < NAME_MAX) begin
                                if (r_cmp_idx >= r_name_len || w_rdata != b) begin
                                    n_mismatch = 1'b1;
                                end
                                n_cmp_idx = r_cmp_idx + 1'b1;
                            end
                        end
                    end
                    PH_QUAL: begin
                        if (b == CH_LF) begin
                            if (!r_line_start) begin
                                if (r_qual_cnt == r_base_cnt) begin
                                    n_done  = 1'b1;
                                    n_len   = r_base_cnt;
                                    n_phase = PH_HEADER;
                                end else if (r_qual_cnt > r_base_cnt) begin
                                    n_err   = ERR_LENGTH;
                                    n_phase = PH_HALT;
                                end
                                n_line_start = 1'b1;
                            end
                        end else begin
                            n_class      = CLS_QUAL;
                            n_qual_cnt   = (&r_qual_cnt) ? r_qual_cnt
                                                         : r_qual_cnt + 1'b1;
                            n_line_start = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_HALT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_name_len   <= '0;
            r_cmp_idx    <= '0;
            r_mismatch   <= 1'b0;
            r_base_cnt   <= '0;
            r_qual_cnt   <= '0;
            r_line_start <= 1'b1;
            r_line_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_name_len   <= n_name_len;
            r_cmp_idx    <= n_cmp_idx;
            r_mismatch   <= n_mismatch;
            r_base_cnt   <= n_base_cnt;
            r_qual_cnt   <= n_qual_cnt;
            r_line_start <= n_line_start;
            r_line_cnt   <= n_line_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_class <= n_class;
            r_value <= n_value;
            r_done  <= n_done;
            r_noq   <= n_noq;
            r_len   <= n_len;
            r_err   <= n_err;
            r_line  <= n_line;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_byte_class  = r_class;
    assign o_byte_value  = r_value;
    assign o_record_done = r_done;
    assign o_no_quality  = r_noq;
    assign o_read_length = r_len;
    assign o_error_code  = r_err;
    assign o_line_number = r_line;

endmodule
